### rtl/ael_pkg.sv
// shared types and constants for the arithmetic expression lexer
// no dependencies
`default_nettype none

package ael_pkg;

  localparam int unsigned LenW     = 16;
  localparam int unsigned NumW     = 63;
  localparam int unsigned CountW   = 17;
  localparam int unsigned ErrW     = 7;
  localparam int unsigned KindW    = 3;
  localparam int unsigned OpW      = 3;
  localparam int unsigned NumSlots = 3;
  localparam int unsigned SlotCntW = 2;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 64;

  localparam logic [KindW-1:0] KIND_NUMBER = 3'd0;
  localparam logic [KindW-1:0] KIND_OPER   = 3'd1;
  localparam logic [KindW-1:0] KIND_OPEN   = 3'd2;
  localparam logic [KindW-1:0] KIND_CLOSE  = 3'd3;
  localparam logic [KindW-1:0] KIND_END    = 3'd4;

  localparam logic [OpW-1:0] OP_NONE = 3'd0;
  localparam logic [OpW-1:0] OP_ADD  = 3'd1;
  localparam logic [OpW-1:0] OP_SUB  = 3'd2;
  localparam logic [OpW-1:0] OP_MUL  = 3'd3;
  localparam logic [OpW-1:0] OP_DIV  = 3'd4;

  localparam int unsigned ERR_EMPTY    = 0;
  localparam int unsigned ERR_LONG     = 1;
  localparam int unsigned ERR_SPACES   = 2;
  localparam int unsigned ERR_FRACTION = 3;
  localparam int unsigned ERR_INVALID  = 4;
  localparam int unsigned ERR_RANGE    = 5;
  localparam int unsigned ERR_ZERO     = 6;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic REG_MAX_LENGTH = 1'b0;
  localparam logic REG_MAX_NUMBER = 1'b1;

  localparam logic [LenW-1:0]   LEN_RESET = 16'd255;
  localparam logic [NumW-1:0]   NUM_RESET = 63'd1000000;
  localparam logic [CountW-1:0] COUNT_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [OpW-1:0]   op;
    logic [NumW-1:0]  value;
    logic [ErrW-1:0]  err;
    logic             eor;
  } tok_t;

  typedef struct packed {
    logic [NumW-1:0]   acc;
    logic              num_open;
    logic              ovf;
    logic [CountW-1:0] count;
    logic              seen;
    logic [ErrW-1:0]   err;
  } run_t;

endpackage

`default_nettype wire

### rtl/ael_step.sv
// next run state and up to three tokens for one character item
// depends on ael_pkg
`default_nettype none

module ael_step (
  input  wire ael_pkg::run_t                       run_i,
  input  wire ael_pkg::item_t                      item_i,
  input  wire [ael_pkg::LenW-1:0]                  max_length_i,
  input  wire [ael_pkg::NumW-1:0]                  max_number_i,
  output ael_pkg::run_t                            run_o,
  output ael_pkg::tok_t [ael_pkg::NumSlots-1:0]    toks_o,
  output logic [ael_pkg::SlotCntW-1:0]             tok_cnt_o
);
  import ael_pkg::*;

  logic               is_digit;
  logic               is_space;
  logic [OpW-1:0]     op;
  logic [NumW+3:0]    wide;
  run_t               s;
  logic               num_v;
  logic               sym_v;
  logic               end_v;
  tok_t               num_tok;
  tok_t               sym_tok;
  tok_t               end_tok;
  logic [SlotCntW-1:0] idx;

  always_comb begin
    is_digit = (item_i.char_code >= CH_ZERO) && (item_i.char_code <= CH_NINE);
    is_space = (item_i.char_code == CH_SPACE) ||
               ((item_i.char_code >= CH_TAB) && (item_i.char_code <= CH_CR));
    unique case (item_i.char_code)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  op = OP_NONE;
    endcase
  end

  always_comb begin
    s       = run_i;
    wide    = '0;
    num_v   = 1'b0;
    sym_v   = 1'b0;
    end_v   = 1'b0;
    num_tok = '0;
    sym_tok = '0;
    end_tok = '0;

    if (item_i.has_char) begin
      if (s.count != COUNT_MAX) s.count = s.count + 1'b1;
      if (s.count > {1'b0, max_length_i}) s.err[ERR_LONG] = 1'b1;
      if (is_digit) begin
        s.seen = 1'b1;
        if (!s.num_open) begin
          s.num_open = 1'b1;
          s.acc      = '0;
          s.ovf      = 1'b0;
        end
        if (!s.ovf) begin
          // acc * 10 + digit, overflow when anything lands above bit 62
          wide = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) +
                 {{(NumW){1'b0}}, item_i.char_code[3:0]};
          if (|wide[NumW+3:NumW]) s.ovf = 1'b1;
          else s.acc = wide[NumW-1:0];
        end
      end
    end

    // pending number closes on any non-digit or at the end
    if (((item_i.has_char && !is_digit) || item_i.last_char) && s.num_open) begin
      if (s.ovf) begin
        s.err[ERR_RANGE] = 1'b1;
      end else begin
        if (s.acc == '0) s.err[ERR_ZERO] = 1'b1;
        if (s.acc > max_number_i) s.err[ERR_RANGE] = 1'b1;
        num_v         = 1'b1;
        num_tok.kind  = KIND_NUMBER;
        num_tok.value = s.acc;
      end
      s.num_open = 1'b0;
      s.ovf      = 1'b0;
      s.acc      = '0;
    end

    if (item_i.has_char && !is_digit && !is_space) begin
      s.seen = 1'b1;
      if ((item_i.char_code == CH_POINT) || (item_i.char_code == CH_COMMA)) begin
        s.err[ERR_FRACTION] = 1'b1;
      end else if (op != OP_NONE) begin
        sym_v        = 1'b1;
        sym_tok.kind = KIND_OPER;
        sym_tok.op   = op;
      end else if (item_i.char_code == CH_OPEN) begin
        sym_v        = 1'b1;
        sym_tok.kind = KIND_OPEN;
      end else if (item_i.char_code == CH_CLOSE) begin
        sym_v        = 1'b1;
        sym_tok.kind = KIND_CLOSE;
      end else begin
        s.err[ERR_INVALID] = 1'b1;
      end
    end

    if (item_i.last_char) begin
      if (s.count == '0) s.err[ERR_EMPTY] = 1'b1;
      else if (!s.seen) s.err[ERR_SPACES] = 1'b1;
      end_v        = 1'b1;
      end_tok.kind = KIND_END;
      end_tok.err  = s.err;
      end_tok.eor  = 1'b1;
      s            = '0;
    end
  end

  // pack in order: number, symbol, end
  always_comb begin
    toks_o = '0;
    idx    = '0;
    if (num_v) begin
      toks_o[idx] = num_tok;
      idx         = idx + 1'b1;
    end
    if (sym_v) begin
      toks_o[idx] = sym_tok;
      idx         = idx + 1'b1;
    end
    if (end_v) begin
      toks_o[idx] = end_tok;
      idx         = idx + 1'b1;
    end
    tok_cnt_o = idx;
    run_o     = s;
  end

endmodule

`default_nettype wire

### rtl/arithmetic_expression_lexer_core.sv
// arithmetic expression lexer: an accepted item is registered in item_r, then its
// tokens in res_r; one item per cycle while each item yields at most one token and
// out_stall stays low; an item yielding more (up to 3) holds the input side until
// the single result port is taking the last token of the three-slot token buffer
// reset (rst_n low, synchronous) clears run state and buffers, max_length to 255,
// max_number to 1000000; depends on ael_pkg and ael_step
`default_nettype none

module arithmetic_expression_lexer_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [ael_pkg::AddrW-1:0]     paddr,
  input  wire [ael_pkg::DataW-1:0]     pwdata,
  output logic [ael_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [7:0]                    in_char_code,
  input  wire                          in_has_char,
  input  wire                          in_last_char,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [ael_pkg::KindW-1:0]    out_token_kind,
  output logic [ael_pkg::OpW-1:0]      out_operator_code,
  output logic [ael_pkg::NumW-1:0]     out_number_value,
  output logic [ael_pkg::ErrW-1:0]     out_error_mask,
  output logic                         out_end_of_run
);
  import ael_pkg::*;

  logic [LenW-1:0]          max_length_r, max_length_nxt;
  logic [NumW-1:0]          max_number_r, max_number_nxt;
  logic                     item_valid_r, item_valid_nxt;
  item_t                    item_r, item_nxt;
  run_t                     run_r, run_nxt, run_step;
  tok_t [NumSlots-1:0]      res_r, res_nxt, toks;
  logic [SlotCntW-1:0]      cnt_r, cnt_nxt, tok_cnt;
  logic                     pop;
  logic                     room;
  logic                     consume;
  logic                     wr_en;

  ael_step u_step (
    .run_i        (run_r),
    .item_i       (item_r),
    .max_length_i (max_length_r),
    .max_number_i (max_number_r),
    .run_o        (run_step),
    .toks_o       (toks),
    .tok_cnt_o    (tok_cnt)
  );

  // register port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    max_length_nxt = max_length_r;
    max_number_nxt = max_number_r;
    if (wr_en) begin
      unique case (paddr[3])
        REG_MAX_LENGTH: max_length_nxt = pwdata[LenW-1:0];
        REG_MAX_NUMBER: max_number_nxt = pwdata[NumW-1:0];
        default:        max_length_nxt = max_length_r;
      endcase
    end
    unique case (paddr[3])
      REG_MAX_LENGTH: prdata = {{(DataW-LenW){1'b0}}, max_length_r};
      REG_MAX_NUMBER: prdata = {{(DataW-NumW){1'b0}}, max_number_r};
      default:        prdata = '0;
    endcase
  end

  // handshake
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r == '0) || ((cnt_r == SlotCntW'(1)) && pop);
  assign consume   = item_valid_r && room;
  assign in_stall  = item_valid_r && !consume;

  always_comb begin
    item_valid_nxt = item_valid_r;
    item_nxt       = item_r;
    if (!in_stall) begin
      item_valid_nxt      = in_valid;
      item_nxt.char_code  = in_char_code;
      item_nxt.has_char   = in_has_char;
      item_nxt.last_char  = in_last_char;
    end

    run_nxt = consume ? run_step : run_r;

    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (consume) begin
      res_nxt = toks;
      cnt_nxt = tok_cnt;
    end else if (pop) begin
      res_nxt = {tok_t'('0), res_r[NumSlots-1:1]};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= LEN_RESET;
      max_number_r <= NUM_RESET;
      item_valid_r <= 1'b0;
      run_r        <= '0;
      cnt_r        <= '0;
    end else begin
      max_length_r <= max_length_nxt;
      max_number_r <= max_number_nxt;
      item_valid_r <= item_valid_nxt;
      run_r        <= run_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_token_kind    = res_r[0].kind;
  assign out_operator_code = res_r[0].op;
  assign out_number_value  = res_r[0].value;
  assign out_error_mask    = res_r[0].err;
  assign out_end_of_run    = res_r[0].eor;

endmodule

`default_nettype wire

### sim/tb_arithmetic_expression_lexer_core.sv
`timescale 1ns / 100ps
// self-checking testbench for arithmetic_expression_lexer_core: feeds expressions one
// character per item, predicts the token stream and compares each token field by field
// depends on ael_pkg and the lexer rtl only
module tb_arithmetic_expression_lexer_core;
  import ael_pkg::*;

  localparam logic [NumW-1:0]  NUM_TOP         = {NumW{1'b1}};
  localparam logic [LenW-1:0]  LEN_TOP         = {LenW{1'b1}};
  localparam logic [AddrW-1:0] ADDR_MAX_LENGTH = {REG_MAX_LENGTH, 3'b000};
  localparam logic [AddrW-1:0] ADDR_MAX_NUMBER = {REG_MAX_NUMBER, 3'b000};
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_HOLD     = 60;
  localparam int TIMEOUT_NS    = 1_000_000;

  logic             clk     = 1'b0;
  logic             rst_n   = 1'b0;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [7:0]       in_char_code = '0;
  logic             in_has_char  = 1'b0;
  logic             in_last_char = 1'b0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KindW-1:0] out_token_kind;
  logic [OpW-1:0]   out_operator_code;
  logic [NumW-1:0]  out_number_value;
  logic [ErrW-1:0]  out_error_mask;
  logic             out_end_of_run;

  // lexer prediction state and register copies
  run_t            lex_state  = '0;
  logic [LenW-1:0] lim_length = LEN_RESET;
  logic [NumW-1:0] lim_number = NUM_RESET;

  item_t pending_chars[$];
  tok_t  expected_tokens[$];
  item_t next_char;
  tok_t  want_tok;

  logic [7:0] op_chars[4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

  int n_queued   = 0;
  int n_accepted = 0;
  int n_exprs    = 0;
  int n_tokens   = 0;
  int n_fail     = 0;
  int send_max   = 5;
  int recv_max   = 5;
  int send_gap   = 0;
  int recv_wait  = 0;
  bit long_hold_done = 1'b0;

  arithmetic_expression_lexer_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_code      (in_char_code),
    .in_has_char       (in_has_char),
    .in_last_char      (in_last_char),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_token_kind    (out_token_kind),
    .out_operator_code (out_operator_code),
    .out_number_value  (out_number_value),
    .out_error_mask    (out_error_mask),
    .out_end_of_run    (out_end_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tok_t make_token(input logic [KindW-1:0] kind, input logic [OpW-1:0] op,
                                      input logic [NumW-1:0] value, input logic [ErrW-1:0] err,
                                      input logic eor);
    tok_t t;
    t.kind  = kind;
    t.op    = op;
    t.value = value;
    t.err   = err;
    t.eor   = eor;
    return t;
  endfunction

  task automatic end_number();
    if (lex_state.num_open) begin
      lex_state.num_open = 1'b0;
      if (lex_state.ovf) begin
        lex_state.err[ERR_RANGE] = 1'b1;
      end else begin
        if (lex_state.acc == '0) lex_state.err[ERR_ZERO] = 1'b1;
        if (lex_state.acc > lim_number) lex_state.err[ERR_RANGE] = 1'b1;
        expected_tokens.push_back(make_token(KIND_NUMBER, OP_NONE, lex_state.acc, '0, 1'b0));
      end
      lex_state.acc = '0;
      lex_state.ovf = 1'b0;
    end
  endtask

  task automatic lex_item(input item_t it);
    logic [63:0] digit;
    if (it.has_char) begin
      if (lex_state.count != COUNT_MAX) lex_state.count = lex_state.count + 1'b1;
      if (lex_state.count > lim_length) lex_state.err[ERR_LONG] = 1'b1;
      if (it.char_code >= CH_ZERO && it.char_code <= CH_NINE) begin
        digit = 64'(it.char_code - CH_ZERO);
        lex_state.seen = 1'b1;
        if (!lex_state.num_open) begin
          lex_state.num_open = 1'b1;
          lex_state.acc      = '0;
          lex_state.ovf      = 1'b0;
        end
        if (!lex_state.ovf) begin
          if ({1'b0, lex_state.acc} > ({1'b0, NUM_TOP} - digit) / 64'd10)
            lex_state.ovf = 1'b1;
          else
            lex_state.acc = lex_state.acc * NumW'(10) + digit[NumW-1:0];
        end
      end else begin
        end_number();
        if (!(it.char_code == CH_SPACE || (it.char_code >= CH_TAB && it.char_code <= CH_CR))) begin
          lex_state.seen = 1'b1;
          case (it.char_code)
            CH_POINT, CH_COMMA: lex_state.err[ERR_FRACTION] = 1'b1;
            CH_PLUS:  expected_tokens.push_back(make_token(KIND_OPER, OP_ADD, '0, '0, 1'b0));
            CH_MINUS: expected_tokens.push_back(make_token(KIND_OPER, OP_SUB, '0, '0, 1'b0));
            CH_STAR:  expected_tokens.push_back(make_token(KIND_OPER, OP_MUL, '0, '0, 1'b0));
            CH_SLASH: expected_tokens.push_back(make_token(KIND_OPER, OP_DIV, '0, '0, 1'b0));
            CH_OPEN:  expected_tokens.push_back(make_token(KIND_OPEN, OP_NONE, '0, '0, 1'b0));
            CH_CLOSE: expected_tokens.push_back(make_token(KIND_CLOSE, OP_NONE, '0, '0, 1'b0));
            default:  lex_state.err[ERR_INVALID] = 1'b1;
          endcase
        end
      end
    end
    if (it.last_char) begin
      end_number();
      if (lex_state.count == '0) lex_state.err[ERR_EMPTY] = 1'b1;
      else if (!lex_state.seen) lex_state.err[ERR_SPACES] = 1'b1;
      expected_tokens.push_back(make_token(KIND_END, OP_NONE, '0, lex_state.err, 1'b1));
      lex_state = '0;
    end
  endtask

  // character driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        lex_item(item_t'({in_char_code, in_has_char, in_last_char}));
        n_accepted++;
        if (in_last_char) n_exprs++;
        send_gap = $urandom_range(0, send_max);
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          next_char = pending_chars.pop_front();
          in_valid     <= 1'b1;
          in_char_code <= next_char.char_code;
          in_has_char  <= next_char.has_char;
          in_last_char <= next_char.last_char;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // token monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_tokens++;
        if (expected_tokens.size() == 0) begin
          $error("token with nothing expected: kind %0d", out_token_kind);
          n_fail++;
        end else begin
          want_tok = expected_tokens.pop_front();
          if (out_token_kind !== want_tok.kind) begin
            $error("token_kind: expected %0d, got %0d", want_tok.kind, out_token_kind);
            n_fail++;
          end
          if (out_operator_code !== want_tok.op) begin
            $error("operator_code: expected %0d, got %0d", want_tok.op, out_operator_code);
            n_fail++;
          end
          if (out_number_value !== want_tok.value) begin
            $error("number_value: expected %0d, got %0d", want_tok.value, out_number_value);
            n_fail++;
          end
          if (out_error_mask !== want_tok.err) begin
            $error("error_mask: expected %b, got %b", want_tok.err, out_error_mask);
            n_fail++;
          end
          if (out_end_of_run !== want_tok.eor) begin
            $error("end_of_run: expected %0d, got %0d", want_tok.eor, out_end_of_run);
            n_fail++;
          end
        end
        recv_wait = $urandom_range(0, recv_max);
        // one long hold while plenty of characters wait, to back the block up
        if (!long_hold_done && n_tokens >= 25 && pending_chars.size() > 20) begin
          recv_wait = LONG_HOLD;
          long_hold_done = 1'b1;
        end
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== data) begin
      $error("register readback at %0h: expected %0h, got %0h", addr, data, prdata);
      n_fail++;
    end
  endtask

  task automatic set_limits(input logic [LenW-1:0] len, input logic [NumW-1:0] num);
    write_reg(ADDR_MAX_LENGTH, DataW'(len));
    write_reg(ADDR_MAX_NUMBER, DataW'(num));
    lim_length = len;
    lim_number = num;
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_char(input logic [7:0] code, input logic has, input logic last);
    item_t it;
    it.char_code = code;
    it.has_char  = has;
    it.last_char = last;
    pending_chars.push_back(it);
    n_queued++;
  endtask

  task automatic push_text(input string s, input bit ends_expr);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], 1'b1, ends_expr && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_blank();
    int code;
    code = $urandom_range(CH_TAB, CH_CR + 1);
    return (code > CH_CR) ? CH_SPACE : 8'(code);
  endfunction

  function automatic logic [7:0] pick_noise();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? CH_POINT : CH_COMMA;
    return 8'($urandom);
  endfunction

  task automatic push_number();
    logic [63:0] value;
    string digits;
    case ($urandom_range(0, 31))
      0:       value = '0;
      1, 2:    value = 64'($urandom_range(0, 2_000_000));
      3:       value = {1'b0, lim_number};
      4:       value = {1'b0, lim_number} + 64'd1;
      5:       value = {1'b0, NUM_TOP};
      6:       value = {1'b0, NUM_TOP} + 64'd1;
      7:       value = {$urandom, $urandom};
      default: value = 64'($urandom_range(0, 9999));
    endcase
    // a leading zero now and then
    if ($urandom_range(0, 7) == 0) push_char(CH_ZERO, 1'b1, 1'b0);
    digits = $sformatf("%0d", value);
    for (int i = 0; i < digits.len(); i++) push_char(digits[i], 1'b1, 1'b0);
  endtask

  // mostly number/operator alternations, with brackets, blanks and stray bytes mixed in
  task automatic queue_expressions(input int n_items);
    int target;
    int n_parts;
    target = n_queued + n_items;
    while (n_queued < target) begin
      case ($urandom_range(0, 15))
        0: push_char(8'($urandom), 1'b0, 1'b1);
        1: begin
          n_parts = $urandom_range(1, 4);
          for (int k = 0; k < n_parts; k++) push_char(pick_blank(), 1'b1, k == n_parts - 1);
        end
        default: begin
          n_parts = $urandom_range(1, 9);
          for (int k = 0; k < n_parts; k++) begin
            if (k % 2 == 0) begin
              case ($urandom_range(0, 9))
                7: begin
                  push_char(CH_OPEN, 1'b1, 1'b0);
                  push_number();
                end
                8:       push_char(pick_blank(), 1'b1, 1'b0);
                9:       push_char(pick_noise(), 1'b1, 1'b0);
                default: push_number();
              endcase
            end else begin
              case ($urandom_range(0, 9))
                0:       push_char(CH_CLOSE, 1'b1, 1'b0);
                1:       push_char(pick_blank(), 1'b1, 1'b0);
                2:       push_char(pick_noise(), 1'b1, 1'b0);
                3:       push_char(8'($urandom), 1'b0, 1'b0);
                default: push_char(op_chars[$urandom_range(0, 3)], 1'b1, 1'b0);
              endcase
            end
          end
          if ($urandom_range(0, 4) == 0)
            push_char(8'($urandom), 1'b0, 1'b1);
          else
            pending_chars[pending_chars.size() - 1].last_char = 1'b1;
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, blanks only, brackets and zero, all operators,
    // point and comma, a gap item, an invalid byte and a number closed by the end
    push_char(8'h00, 1'b0, 1'b1);
    push_text(" \t\n", 1'b1);
    push_text("(10+0)", 1'b1);
    push_text("9-8*7/6", 1'b1);
    push_text("5.2,", 1'b0);
    push_char(8'hA5, 1'b0, 1'b0);
    push_char(8'hFF, 1'b1, 1'b0);
    push_char(CH_CR, 1'b1, 1'b0);
    push_text("3", 1'b1);
    wait_drained();

    set_limits(LenW'(1), NumW'(1));
    queue_expressions(60);
    wait_drained();

    send_max = 0;
    recv_max = 0;
    set_limits(LEN_TOP, NUM_TOP);
    queue_expressions(70);
    wait_drained();

    send_max = 5;
    recv_max = 5;
    set_limits(LenW'($urandom_range(3, 24)), NumW'($urandom_range(1, 50000)));
    queue_expressions(130);
    wait_drained();

    $display("lexed %0d characters in %0d expressions into %0d checked tokens",
             n_accepted, n_exprs, n_tokens);
    $display("limits run from reset values through both extremes to a random pair");
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d tokens outstanding", expected_tokens.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
